[src/bbc_pkg.sv]
// Shared types, codes and bracket decode functions for the bracket balance checker.
package bbc_pkg;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_BALANCED = 3'd1,
    VERDICT_MISMATCH = 3'd2,
    VERDICT_OVERFLOW = 3'd3,
    VERDICT_UNCLOSED = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_MISMATCH = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_cmd_t;

  localparam int unsigned LimitWidth = 11;
  localparam int unsigned CfgDataWidth = 32;
  localparam logic [7:0] ChOpenRound   = 8'h28;
  localparam logic [7:0] ChOpenSquare  = 8'h5B;
  localparam logic [7:0] ChOpenCurly   = 8'h7B;
  localparam logic [7:0] ChCloseRound  = 8'h29;
  localparam logic [7:0] ChCloseSquare = 8'h5D;
  localparam logic [7:0] ChCloseCurly  = 8'h7D;
  localparam logic [LimitWidth-1:0] DepthLimitReset = 11'd1000;

  function automatic kind_e open_kind(input logic [7:0] b);
    kind_e k;
    unique case (b)
      ChOpenRound:  k = KIND_ROUND;
      ChOpenSquare: k = KIND_SQUARE;
      ChOpenCurly:  k = KIND_CURLY;
      default:      k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_e close_kind(input logic [7:0] b);
    kind_e k;
    unique case (b)
      ChCloseRound:  k = KIND_ROUND;
      ChCloseSquare: k = KIND_SQUARE;
      ChCloseCurly:  k = KIND_CURLY;
      default:       k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

[src/bbc_cell.sv]
// One stack cell: holds one bracket kind and shifts with its neighbors on push or pop.
module bbc_cell (
  input  logic               clk_i,
  input  bbc_pkg::shift_cmd_t cmd_i,
  input  bbc_pkg::kind_e     above_i,
  input  bbc_pkg::kind_e     below_i,
  output bbc_pkg::kind_e     kind_o
);
  import bbc_pkg::*;

  kind_e kind_q, kind_d;

  always_comb begin
    priority if (cmd_i.push) begin
      kind_d = above_i;
    end else if (cmd_i.pop) begin
      kind_d = below_i;
    end else begin
      kind_d = kind_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

[src/bracket_balance_checker.sv]
// Top level of the bracket balance checker: control, cell stack, output register, APB port.
// The result of each input transfer is registered in the output register.
// Throughput: one byte per cycle unless output stalls; stack top is always cell 0 of the shifting row.
// Input is taken whenever the output register is empty or being drained the same cycle.
// Reset clears stack count, error state, output valid and restores depth_limit to 1000.
// Stack cells hold no reset value; no clearing pass is needed.
module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [bbc_pkg::CfgDataWidth-1:0]     pwdata,
  output logic [bbc_pkg::CfgDataWidth-1:0]     prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           text_byte_i,
  input  logic                                 is_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bbc_pkg::verdict_e                    verdict_o,
  output logic [bbc_pkg::LimitWidth-1:0]       open_depth_o,
  output logic                                 stream_end_o
);
  import bbc_pkg::*;

  localparam int unsigned CntWidth = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ExtWidth = (CntWidth > LimitWidth) ? CntWidth : LimitWidth;

  logic [LimitWidth-1:0] depth_limit_q;
  logic [CntWidth-1:0]   cnt_q, cnt_d, cnt_new;
  err_e                  err_q, err_d, err_new;
  logic                  out_valid_q;
  verdict_e              verdict_q, verdict_d;
  logic [LimitWidth-1:0] depth_q;
  logic                  end_q;

  logic                  in_fire;
  logic                  cfg_wr;
  logic [ExtWidth-1:0]   limit_ext, cnt_ext, cnt_new_ext;
  kind_e                 ok, ck, top;
  shift_cmd_t            cmd;
  kind_e                 cells [STACK_DEPTH];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : CfgDataWidth'(depth_limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= DepthLimitReset;
    end else if (cfg_wr) begin
      depth_limit_q <= pwdata[LimitWidth-1:0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ok  = open_kind(text_byte_i);
  assign ck  = close_kind(text_byte_i);
  assign top = cells[0];

  assign limit_ext = (ExtWidth'(depth_limit_q) > ExtWidth'(STACK_DEPTH)) ?
                     ExtWidth'(STACK_DEPTH) : ExtWidth'(depth_limit_q);
  assign cnt_ext   = ExtWidth'(cnt_q);

  always_comb begin
    cnt_new  = cnt_q;
    err_new  = err_q;
    cmd.push = 1'b0;
    cmd.pop  = 1'b0;
    if (err_q == ERR_NONE) begin
      if (ok != KIND_NONE) begin
        if (cnt_ext < limit_ext) begin
          cmd.push = in_fire;
          cnt_new  = cnt_q + CntWidth'(1);
        end else begin
          err_new = ERR_OVERFLOW;
        end
      end else if (ck != KIND_NONE) begin
        if (cnt_q != '0) begin
          cmd.pop = in_fire;
          cnt_new = cnt_q - CntWidth'(1);
          if (top != ck) begin
            err_new = ERR_MISMATCH;
          end
        end else begin
          err_new = ERR_MISMATCH;
        end
      end
    end

    priority if (err_new == ERR_OVERFLOW) begin
      verdict_d = VERDICT_OVERFLOW;
    end else if (err_new == ERR_MISMATCH) begin
      verdict_d = VERDICT_MISMATCH;
    end else if (is_last_i) begin
      verdict_d = (cnt_new == '0) ? VERDICT_BALANCED : VERDICT_UNCLOSED;
    end else begin
      verdict_d = VERDICT_OK;
    end

    cnt_d = cnt_q;
    err_d = err_q;
    if (in_fire) begin
      cnt_d = is_last_i ? '0 : cnt_new;
      err_d = is_last_i ? ERR_NONE : err_new;
    end
  end

  assign cnt_new_ext = ExtWidth'(cnt_new);

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_e above, below;
    if (i == 0) begin : g_head
      assign above = ok;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = cells[i];
    end else begin : g_body
      assign below = cells[i+1];
    end
    bbc_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .above_i (above),
      .below_i (below),
      .kind_o  (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      verdict_q <= verdict_d;
      depth_q   <= cnt_new_ext[LimitWidth-1:0];
      end_q     <= is_last_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign open_depth_o = depth_q;
  assign stream_end_o = end_q;

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_last_i |=> cnt_q == '0 && err_q == ERR_NONE)
    else $error("stream state not cleared after final byte");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ExtWidth'(cnt_q) <= ExtWidth'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && err_q != ERR_NONE |=> out_valid_o &&
      (verdict_o == VERDICT_MISMATCH || verdict_o == VERDICT_OVERFLOW))
    else $error("latched error not reported");

  a_no_shift_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ERR_NONE |-> !cmd.push && !cmd.pop)
    else $error("stack shifted while error latched");
`endif

endmodule

[bench/tb_bracket_balance_checker.sv]
// Self-checking testbench for the bracket balance checker: directed, random and deep streams.
`timescale 1ns / 100ps

module tb_bracket_balance_checker;
  import bbc_pkg::*;

  localparam int unsigned STACK_SLOTS = 1024;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS = 30;
  localparam int unsigned DEEP_OPENS = 100;
  localparam logic [2:0] ADDR_DEPTH_LIMIT = 3'd0;

  typedef struct {
    verdict_e              verdict;
    logic [LimitWidth-1:0] depth;
    logic                  stream_end;
  } verdict_item_t;

  class bracket_scoreboard;
    logic [LimitWidth-1:0] depth_limit;
    kind_e                 kinds[STACK_SLOTS];
    int unsigned           open_cnt;
    err_e                  err;
    verdict_item_t         pending_q[$];
    int unsigned           failures;

    function new();
      depth_limit = DepthLimitReset;
      open_cnt = 0;
      err = ERR_NONE;
      failures = 0;
    endfunction

    function void set_limit(logic [LimitWidth-1:0] v);
      depth_limit = v;
    endfunction

    function kind_e opener(logic [7:0] b);
      case (b)
        ChOpenRound:  return KIND_ROUND;
        ChOpenSquare: return KIND_SQUARE;
        ChOpenCurly:  return KIND_CURLY;
        default:      return KIND_NONE;
      endcase
    endfunction

    function kind_e closer(logic [7:0] b);
      case (b)
        ChCloseRound:  return KIND_ROUND;
        ChCloseSquare: return KIND_SQUARE;
        ChCloseCurly:  return KIND_CURLY;
        default:       return KIND_NONE;
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic last);
      verdict_item_t e;
      kind_e         ok;
      kind_e         ck;
      int unsigned   lim;
      lim = (depth_limit > STACK_SLOTS) ? STACK_SLOTS : depth_limit;
      ok = opener(b);
      ck = closer(b);
      if (err == ERR_NONE) begin
        if (ok != KIND_NONE) begin
          if (open_cnt < lim) begin
            kinds[open_cnt] = ok;
            open_cnt++;
          end else begin
            err = ERR_OVERFLOW;
          end
        end else if (ck != KIND_NONE) begin
          if (open_cnt > 0) begin
            open_cnt--;
            if (kinds[open_cnt] != ck) err = ERR_MISMATCH;
          end else begin
            err = ERR_MISMATCH;
          end
        end
      end
      if (err == ERR_OVERFLOW) e.verdict = VERDICT_OVERFLOW;
      else if (err == ERR_MISMATCH) e.verdict = VERDICT_MISMATCH;
      else if (last) e.verdict = (open_cnt == 0) ? VERDICT_BALANCED : VERDICT_UNCLOSED;
      else e.verdict = VERDICT_OK;
      e.depth = LimitWidth'(open_cnt);
      e.stream_end = last;
      pending_q.push_back(e);
      if (last) begin
        open_cnt = 0;
        err = ERR_NONE;
      end
    endfunction

    function void check_result(logic [2:0] verdict, logic [LimitWidth-1:0] depth, logic fin);
      verdict_item_t e;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: verdict %0d depth %0d end %0d",
                 $time, verdict, depth, fin);
        failures++;
        return;
      end
      e = pending_q.pop_front();
      if (verdict !== e.verdict) begin
        $display("%0t verdict: expected %0d actual %0d", $time, e.verdict, verdict);
        failures++;
      end
      if (depth !== e.depth) begin
        $display("%0t open_depth: expected %0d actual %0d", $time, e.depth, depth);
        failures++;
      end
      if (fin !== e.stream_end) begin
        $display("%0t stream_end: expected %0d actual %0d", $time, e.stream_end, fin);
        failures++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [2:0]              paddr = '0;
  logic [CfgDataWidth-1:0] pwdata = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [7:0]              text_byte_i = '0;
  logic                    is_last_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  verdict_e                verdict_o;
  logic [LimitWidth-1:0]   open_depth_o;
  logic                    stream_end_o;

  bracket_scoreboard sb = new();
  int unsigned       cycles = 0;
  int unsigned       items_sent = 0;
  bit                in_no_gap = 1'b0;
  bit                out_no_gap = 1'b0;

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_SLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .verdict_o    (verdict_o),
    .open_depth_o (open_depth_o),
    .stream_end_o (stream_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_bracket_balance_checker NOT OK");
      $finish;
    end
  end

  function automatic logic [7:0] open_char(kind_e k);
    case (k)
      KIND_ROUND:  return ChOpenRound;
      KIND_SQUARE: return ChOpenSquare;
      default:     return ChOpenCurly;
    endcase
  endfunction

  function automatic logic [7:0] close_char(kind_e k);
    case (k)
      KIND_ROUND:  return ChCloseRound;
      KIND_SQUARE: return ChCloseSquare;
      default:     return ChCloseCurly;
    endcase
  endfunction

  function automatic int unsigned draw_gap(inout bit no_gap);
    if ($urandom_range(0, 29) == 0) no_gap = ~no_gap;
    return no_gap ? 0 : $urandom_range(0, 19);
  endfunction

  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(out_no_gap);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(verdict_o, open_depth_o, stream_end_o);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = draw_gap(in_no_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    is_last_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(b, last);
    items_sent++;
  endtask

  task automatic send_queue(ref logic [7:0] bq[$]);
    foreach (bq[i]) send_byte(bq[i], i == bq.size() - 1);
  endtask

  task automatic send_text(string s);
    logic [7:0] bq[$];
    for (int i = 0; i < s.len(); i++) bq.push_back(s[i]);
    send_queue(bq);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [CfgDataWidth-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_DEPTH_LIMIT;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata !== wdata) begin
      $display("%0t depth_limit read: expected %0d actual %0d", $time, wdata, prdata);
      sb.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_depth_limit(logic [LimitWidth-1:0] v);
    wait_idle();
    apb_access(1'b1, CfgDataWidth'(v));
    sb.set_limit(v);
    apb_access(1'b0, CfgDataWidth'(v));
  endtask

  task automatic random_stream(int unsigned lim);
    logic [7:0]  bq[$];
    kind_e       kq[$];
    int unsigned len;
    int unsigned cap;
    int unsigned r;
    bit          broken;
    kind_e       k;
    broken = ($urandom_range(0, 3) == 0);
    len = $urandom_range(1, 20);
    cap = (lim < 12) ? lim + 1 : 12;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      k = kind_e'($urandom_range(0, 2));
      if (broken) begin
        if (r < 5) bq.push_back(r[0] ? open_char(k) : close_char(k));
        else bq.push_back(8'($urandom_range(0, 255)));
      end else if (r < 4 && kq.size() < cap) begin
        kq.push_back(k);
        bq.push_back(open_char(k));
      end else if (r < 7 && kq.size() > 0) begin
        bq.push_back(close_char(kq.pop_back()));
      end else begin
        bq.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (!broken && $urandom_range(0, 4) != 0)
      while (kq.size() > 0) bq.push_back(close_char(kq.pop_back()));
    send_queue(bq);
  endtask

  task automatic deep_stream(int unsigned n_open, bit close_all);
    logic [7:0] bq[$];
    kind_e      kq[$];
    kind_e      k;
    for (int i = 0; i < n_open; i++) begin
      k = kind_e'($urandom_range(0, 2));
      kq.push_back(k);
      bq.push_back(open_char(k));
    end
    if (close_all) begin
      while (kq.size() > 0) bq.push_back(close_char(kq.pop_back()));
    end else begin
      bq.push_back(ChCloseCurly);
      bq.push_back(8'h41);
    end
    send_queue(bq);
  endtask

  task automatic random_phase(logic [LimitWidth-1:0] lim);
    int unsigned target;
    set_depth_limit(lim);
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) random_stream((lim > STACK_SLOTS) ? STACK_SLOTS : lim);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("()");
    send_text("([{}])\n");
    send_text("(]()");
    send_text(")a");
    send_text("{[");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    set_depth_limit(11'd1);
    send_text("(()");
    set_depth_limit(11'd0);
    send_text("(");
    send_text("a");

    random_phase(DepthLimitReset);
    random_phase(11'd1);
    random_phase(11'd2);
    random_phase(11'd3);
    random_phase(11'd5);
    random_phase(11'd0);
    random_phase(11'($urandom_range(1, 20)));
    random_phase(11'd9);

    set_depth_limit(11'(DEEP_OPENS));
    deep_stream(DEEP_OPENS, 1'b1);
    deep_stream(DEEP_OPENS + 1, 1'b0);

    random_phase(11'd2047);
    random_phase(11'($urandom_range(1, 1024)));

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_q.size() != 0) sb.failures++;
    if (sb.failures == 0) begin
      $display("tb_bracket_balance_checker OK");
    end else begin
      $display("tb_bracket_balance_checker NOT OK");
    end
    $finish;
  end

endmodule
